### rtl/core/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

   // Field widths of the request, response and configuration beats.
   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 31;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 7;
   localparam int CFG_W    = 8;

   // Default storage depth and the reset value of the size register.
   localparam int DEFAULT_SLOTS = 128;
   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 8'd128;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

endpackage

`default_nettype wire

### rtl/core/lpht_if.sv
`default_nettype none

interface lpht_req_if import lpht_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] item_value;

   modport source (output valid, output command, output item_value, input ready);
   modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;

   modport source (output valid, output status, output slot_index, input ready);
   modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

### rtl/core/lpht_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/lpht_mod.sv
`default_nettype none

// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// The remainder is valid in the cycle that done is high.
module lpht_mod import lpht_pkg::*; #(
   parameter int DIV_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [VALUE_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]   divisor,
   output logic                    done,
   output logic      [DIV_W-1:0]   remainder
);

   localparam int STEP_W = $clog2(VALUE_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[VALUE_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(VALUE_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         if (trial >= {1'b0, dvs_ff}) begin
            trial = trial - {1'b0, dvs_ff};
         end
         rem_in  = trial[DIV_W-1:0];
         quo_in  = {quo_ff[VALUE_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/core/linear_probe_hash_table.sv
`default_nettype none

// Channel   Role      Beat contents
// req_bus   sink      command, item_value
// rsp_bus   source    status, slot_index
// csr_*     write     csr_wr_data (table size, 8 bits)
//
// One request is worked on at a time. From accept to the next accept, the serial
// remainder unit first finds the home slot, then the slot RAM is read once per cycle
// along the probe sequence, which probes from 1 up to the live table size slots. After
// reset a clearing pass walks the slot RAM, and no request is taken until it ends. A
// finished response waits in the output register while the next request is taken; only
// its successor stalls.
module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lpht_req_if.sink              req_bus,
   lpht_rsp_if.source            rsp_bus,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   // Index width addresses every slot; count width also holds the slot count itself.
   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int SZ_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int WORD_W = VALUE_W + 1;

   // Controller states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIVIDE = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CFG_W-1:0]    csr_size_ff, csr_size_in;
   logic [CNT_W-1:0]    size_ff, size_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]    issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                chk_last_ff, chk_last_in;
   logic [IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_slot_ff, res_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic [SZ_W-1:0]     cfg_wide;
   logic [SZ_W-1:0]     live_wide;
   logic [CNT_W-1:0]    live_size;
   logic                req_take;
   logic                div_start;
   logic                div_done;
   logic [CNT_W-1:0]    div_rem;
   logic [IDX_W:0]      issue_next;
   logic                issuing;
   logic                slot_occ;
   logic                slot_hit;
   logic                probe_end;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [WORD_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [WORD_W-1:0]   ram_rd_data;

   // Live size: a programmed zero acts as one, anything past the storage saturates.
   always_comb begin
      cfg_wide = SZ_W'(csr_size_ff);
      if (cfg_wide == '0) begin
         live_wide = SZ_W'(1);
      end else if (cfg_wide > SZ_W'(TABLE_SLOTS)) begin
         live_wide = SZ_W'(TABLE_SLOTS);
      end else begin
         live_wide = cfg_wide;
      end
      live_size = live_wide[CNT_W-1:0];
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign div_start     = req_take && (req_bus.command inside {CMD_INSERT, CMD_DELETE,
                                                               CMD_SEARCH});

   // Home slot: item_value modulo the live size.
   lpht_mod #(
      .DIV_W (CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_bus.item_value),
      .divisor   (live_size),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Each RAM word holds an occupied flag above the stored value.
   lpht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rd_data)
   );

   // The check stage looks at the word read in the previous cycle. Insert stops at
   // the first free slot, delete and search at the first occupied slot that matches.
   assign slot_occ = ram_rd_data[VALUE_W];
   always_comb begin
      if (cmd_ff == CMD_INSERT) begin
         slot_hit = !slot_occ;
      end else begin
         slot_hit = slot_occ && (ram_rd_data[VALUE_W-1:0] == val_ff);
      end
   end
   assign probe_end  = chk_vld_ff && (slot_hit || chk_last_ff);
   assign issuing    = (state_ff == S_PROBE) && (issue_cnt_ff != size_ff);
   assign issue_next = {1'b0, issue_idx_ff} + 1'b1;
   assign ram_rd_en  = issuing;

   always_comb begin
      state_in      = state_ff;
      csr_size_in   = csr_size_ff;
      size_in       = size_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      clr_idx_in    = clr_idx_ff;
      issue_idx_in  = issue_idx_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_vld_in    = 1'b0;
      chk_last_in   = chk_last_ff;
      chk_idx_in    = chk_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = chk_idx_ff;
      ram_wr_data   = {cmd_ff == CMD_INSERT, val_ff};
      slot_ext      = {{SLOT_W{1'b0}}, res_slot_ff};

      if (csr_wr_en) begin
         csr_size_in = csr_wr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            ram_wr_data = '0;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // An unused command code is taken and dropped without a response.
            if (div_start) begin
               cmd_in   = req_bus.command;
               val_in   = req_bus.item_value;
               size_in  = live_size;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               issue_idx_in = div_rem[IDX_W-1:0];
               issue_cnt_in = '0;
               state_in     = S_PROBE;
            end
         end
         S_PROBE: begin
            if (issuing) begin
               chk_vld_in   = !probe_end;
               chk_last_in  = (issue_cnt_ff == size_ff - 1'b1);
               chk_idx_in   = issue_idx_ff;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               if (issue_next >= (IDX_W+1)'(size_ff)) begin
                  issue_idx_in = '0;
               end else begin
                  issue_idx_in = issue_next[IDX_W-1:0];
               end
            end
            if (probe_end) begin
               state_in = S_DONE;
               if (slot_hit) begin
                  res_status_in = ST_DONE;
                  res_slot_in   = chk_idx_ff;
                  ram_wr_en     = (cmd_ff == CMD_INSERT) || (cmd_ff == CMD_DELETE);
               end else begin
                  res_status_in = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_MISSING;
                  res_slot_in   = '0;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_ext[SLOT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         csr_size_ff  <= CFG_SIZE_RESET;
         clr_idx_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_size_ff  <= csr_size_in;
         clr_idx_ff   <= clr_idx_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff       <= size_in;
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      issue_idx_ff  <= issue_idx_in;
      issue_cnt_ff  <= issue_cnt_in;
      chk_last_ff   <= chk_last_in;
      chk_idx_ff    <= chk_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.slot_index = rsp_slot_ff;

   // A word under check only exists while the probe walk is running.
   a_check_in_probe: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> state_ff == S_PROBE)
      else $error("check stage active outside the probe walk");

   // The remainder unit only finishes while the controller waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVIDE)
      else $error("remainder finished outside the divide state");

   // The probe walk never reads more slots than the live size.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> issue_cnt_ff <= size_ff)
      else $error("probe walk overran the live size");

   // A failed command reports slot zero.
   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_DONE) |-> rsp_slot_ff == '0)
      else $error("failed command carries a nonzero slot");

endmodule

`default_nettype wire
